/* hw/rtl/rdmc_pkg.sv */
// ----------------------------------------------------------------------------
// rdmc_pkg: shared definitions for the maze carver
// Constants, register map, direction codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rdmc_pkg;

  // Default largest grid side, in cells.
  localparam int RDMC_MAX_SIDE = 64;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_CELLS_PER_SIDE = 2'd0;
  localparam logic [1:0] REG_START_X        = 2'd1;
  localparam logic [1:0] REG_START_Y        = 2'd2;

  // Register reset values.
  localparam logic [6:0] CELLS_PER_SIDE_RST = 7'd64;
  localparam logic [5:0] START_X_RST        = 6'd0;
  localparam logic [5:0] START_Y_RST        = 6'd0;

  // Input mode codes.
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_DRAW    = 1'b1;

  // Direction codes of a draw and of a stored parent link.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Which visited-map row a read fetches.
  typedef enum logic [1:0] {
    ROW_NONE,
    ROW_UP,
    ROW_MID,
    ROW_DOWN
  } row_sel_t;

  // What the result register is loaded with.
  typedef enum logic [1:0] {
    RES_RESTART,
    RES_FINISH,
    RES_CARVE,
    RES_REJECT
  } res_kind_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic      take;       // capture the draw of the accepted word
    logic      restart;    // latch configuration and reset the walk
    row_sel_t  rd_row;     // visited-map row read to issue
    logic      back_step;  // move the walker to its parent cell
    logic      carve;      // open the wall and move to the drawn cell
    logic      set_done;   // the walk has ended
    logic      load;       // load the result register
    res_kind_t res;        // kind of result to load
  } rdmc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic done;        // walk ended or never started
    logic unvisited;   // current cell has an unvisited neighbor
    logic at_start;    // walker sits on the start cell
    logic parent_ok;   // parent link points inside the grid
    logic draw_ok;     // drawn neighbor is inside the grid and unvisited
  } rdmc_sts_t;

endpackage

/* hw/rtl/random_dfs_maze_carver_core.sv */
// ----------------------------------------------------------------------------
// random_dfs_maze_carver_core: randomized depth-first maze carver
// A restart word resets the walk at the start cell; each draw word either
// carves one wall pixel or is rejected, backtracking first where needed.
// A draw word reads the rows above, at and below the walker one after the
// other through the single read port of the visited map, then decides once
// the result register is free; each backtrack step along the parent chain
// repeats those three reads. A restart word, and a draw after the walk has
// ended, need no row reads. The visited map keeps a valid bit per row, so
// restart needs no clearing pass. Configuration takes effect at the next
// restart word.
// ----------------------------------------------------------------------------
module random_dfs_maze_carver_core #(
  parameter int MAX_SIDE = rdmc_pkg::RDMC_MAX_SIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdmc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rdmc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rdmc_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  // Input words.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [1:0]                    draw,
  // Result words.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          carved,
  output logic [6:0]                    wall_x,
  output logic [6:0]                    wall_y,
  output logic                          finished
);
  import rdmc_pkg::*;

  logic [6:0] cfg_side;
  logic [5:0] cfg_start_x;
  logic [5:0] cfg_start_y;
  logic       cfg_wr;
  rdmc_cmd_t  cmd;
  rdmc_sts_t  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_side    <= CELLS_PER_SIDE_RST;
      cfg_start_x <= START_X_RST;
      cfg_start_y <= START_Y_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CELLS_PER_SIDE: cfg_side    <= pwdata[6:0];
        REG_START_X:        cfg_start_x <= pwdata[5:0];
        REG_START_Y:        cfg_start_y <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      REG_CELLS_PER_SIDE: prdata = APB_DATA_W'(cfg_side);
      REG_START_X:        prdata = APB_DATA_W'(cfg_start_x);
      REG_START_Y:        prdata = APB_DATA_W'(cfg_start_y);
      default:            prdata = '0;
    endcase
  end

  rdmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdmc_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_side    (cfg_side),
    .cfg_start_x (cfg_start_x),
    .cfg_start_y (cfg_start_y),
    .draw        (draw),
    .cmd         (cmd),
    .sts         (sts),
    .carved      (carved),
    .wall_x      (wall_x),
    .wall_y      (wall_y),
    .finished    (finished)
  );

endmodule

/* hw/rtl/rdmc_dp.sv */
// ----------------------------------------------------------------------------
// rdmc_dp: maze carver datapath
// Walker position, latched grid, the row-organized visited map with per-row
// valid bits, the parent direction memory and the result register.
// ----------------------------------------------------------------------------
module rdmc_dp #(
  parameter int MAX_SIDE = rdmc_pkg::RDMC_MAX_SIDE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         cfg_side,
  input  logic [5:0]         cfg_start_x,
  input  logic [5:0]         cfg_start_y,
  input  logic [1:0]         draw,
  input  rdmc_pkg::rdmc_cmd_t cmd,
  output rdmc_pkg::rdmc_sts_t sts,
  output logic               carved,
  output logic [6:0]         wall_x,
  output logic [6:0]         wall_y,
  output logic               finished
);
  import rdmc_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam logic [6:0] SIDE_CAP = (MAX_SIDE < 128) ? 7'(MAX_SIDE) : 7'd127;
  localparam logic [MAX_SIDE-1:0] ROW_ONE = {{(MAX_SIDE-1){1'b0}}, 1'b1};

  // Walk state.
  logic [CW-1:0] wx, wy, sx_l, sy_l;
  logic [SW-1:0] side_l;
  logic [1:0]    draw_q;
  logic          done_flag;

  // Visited map: one row of cells per word, a valid bit per row.
  logic [MAX_SIDE-1:0] vis_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld;
  logic [MAX_SIDE-1:0] rd_row;
  logic                rd_vld;
  logic [MAX_SIDE-1:0] rd_out;
  row_sel_t            rd_pend;
  logic [MAX_SIDE-1:0] up_row, mid_row;
  logic [CW-1:0]       rd_addr, up_addr, dn_addr;

  // Parent direction memory.
  logic [1:0]    bd_mem [CELLS];
  logic [1:0]    bd_q;

  // Restart values.
  logic [6:0]    n_clamp, sx_w, sy_w;
  logic [CW-1:0] rs_x, rs_y;

  // Neighbor evaluation, indexed by direction code.
  logic [3:0]    ok_v, vis_v;
  logic [CW-1:0] nx_v [4];
  logic [CW-1:0] ny_v [4];
  logic [CW-1:0] xp, xm;
  logic [CW-1:0] tx, ty, px, py;
  logic [MAX_SIDE-1:0] tgt_row;

  // Cell address of the parent direction memory.
  function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cell_idx = IW'(y) * IW'(MAX_SIDE) + IW'(x);
  endfunction

  // Clamp the configuration at restart.
  always_comb begin
    n_clamp = cfg_side;
    if (cfg_side < 7'd2) begin
      n_clamp = 7'd2;
    end else if (cfg_side > SIDE_CAP) begin
      n_clamp = SIDE_CAP;
    end
    sx_w = ({1'b0, cfg_start_x} < n_clamp) ? {1'b0, cfg_start_x} : n_clamp - 7'd1;
    sy_w = ({1'b0, cfg_start_y} < n_clamp) ? {1'b0, cfg_start_y} : n_clamp - 7'd1;
    rs_x = CW'(sx_w);
    rs_y = CW'(sy_w);
  end

  // Row addresses around the walker; an off-grid row reads a harmless row.
  assign up_addr = (wy == '0) ? wy : wy - CW'(1);
  assign dn_addr = (wy == CW'(MAX_SIDE - 1)) ? wy : wy + CW'(1);

  always_comb begin
    case (cmd.rd_row)
      ROW_UP:   rd_addr = up_addr;
      ROW_DOWN: rd_addr = dn_addr;
      default:  rd_addr = wy;
    endcase
  end

  // A row that was not written since restart reads as all unvisited.
  assign rd_out = rd_vld ? rd_row : '0;

  // Neighbor tests; the down row is still in the read register.
  always_comb begin
    xp = wx + CW'(1);
    xm = wx - CW'(1);
    ok_v[DIR_UP]    = (wy != '0);
    ok_v[DIR_RIGHT] = (SW'(wx) + SW'(1) < side_l);
    ok_v[DIR_DOWN]  = (SW'(wy) + SW'(1) < side_l);
    ok_v[DIR_LEFT]  = (wx != '0);
    vis_v[DIR_UP]    = up_row[wx];
    vis_v[DIR_RIGHT] = mid_row[xp];
    vis_v[DIR_DOWN]  = rd_out[wx];
    vis_v[DIR_LEFT]  = mid_row[xm];
    nx_v[DIR_UP]    = wx;
    ny_v[DIR_UP]    = wy - CW'(1);
    nx_v[DIR_RIGHT] = xp;
    ny_v[DIR_RIGHT] = wy;
    nx_v[DIR_DOWN]  = wx;
    ny_v[DIR_DOWN]  = wy + CW'(1);
    nx_v[DIR_LEFT]  = xm;
    ny_v[DIR_LEFT]  = wy;
    tx = nx_v[draw_q];
    ty = ny_v[draw_q];
    px = nx_v[bd_q];
    py = ny_v[bd_q];
    case (draw_q)
      DIR_UP:   tgt_row = up_row | (ROW_ONE << tx);
      DIR_DOWN: tgt_row = rd_out | (ROW_ONE << tx);
      default:  tgt_row = mid_row | (ROW_ONE << tx);
    endcase
  end

  assign sts.done      = done_flag;
  assign sts.unvisited = |(ok_v & ~vis_v);
  assign sts.at_start  = (wx == sx_l) && (wy == sy_l);
  assign sts.parent_ok = ok_v[bd_q];
  assign sts.draw_ok   = ok_v[draw_q] && !vis_v[draw_q];

  // Walk control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag <= 1'b1;
      wx        <= '0;
      wy        <= '0;
      side_l    <= SW'(2);
      sx_l      <= '0;
      sy_l      <= '0;
      row_vld   <= '0;
      rd_pend   <= ROW_NONE;
    end else begin
      rd_pend <= cmd.rd_row;
      if (cmd.restart) begin
        side_l    <= SW'(n_clamp);
        sx_l      <= rs_x;
        sy_l      <= rs_y;
        wx        <= rs_x;
        wy        <= rs_y;
        done_flag <= 1'b0;
        row_vld   <= ROW_ONE << rs_y;
      end
      if (cmd.carve) begin
        row_vld[ty] <= 1'b1;
        wx          <= tx;
        wy          <= ty;
      end
      if (cmd.back_step) begin
        wx <= px;
        wy <= py;
      end
      if (cmd.set_done) begin
        done_flag <= 1'b1;
      end
    end
  end

  // Payload registers: draw, captured rows, result.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      draw_q <= draw;
    end
    if (rd_pend == ROW_UP) begin
      up_row <= rd_out;
    end
    if (rd_pend == ROW_MID) begin
      mid_row <= rd_out;
    end
    if (cmd.load) begin
      case (cmd.res)
        RES_CARVE: begin
          carved   <= 1'b1;
          wall_x   <= 7'(wx) + 7'(tx);
          wall_y   <= 7'(wy) + 7'(ty);
          finished <= 1'b0;
        end
        RES_FINISH: begin
          carved   <= 1'b0;
          wall_x   <= '0;
          wall_y   <= '0;
          finished <= 1'b1;
        end
        default: begin
          carved   <= 1'b0;
          wall_x   <= '0;
          wall_y   <= '0;
          finished <= 1'b0;
        end
      endcase
    end
  end

  // Visited map: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      vis_mem[rs_y] <= ROW_ONE << rs_x;
    end else if (cmd.carve) begin
      vis_mem[ty] <= tgt_row;
    end
    if (cmd.rd_row != ROW_NONE) begin
      rd_row <= vis_mem[rd_addr];
      rd_vld <= row_vld[rd_addr];
    end
  end

  // Parent directions: written on carve, read with the upper row.
  always_ff @(posedge clk) begin
    if (cmd.carve) begin
      bd_mem[cell_idx(tx, ty)] <= draw_q + 2'd2;
    end
    if (cmd.rd_row == ROW_UP) begin
      bd_q <= bd_mem[cell_idx(wx, wy)];
    end
  end

endmodule

/* hw/rtl/rdmc_ctrl.sv */
// ----------------------------------------------------------------------------
// rdmc_ctrl: maze carver controller
// Sequences the row reads around the walker, the backtrack steps and the
// final decision of each word, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rdmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  rdmc_pkg::rdmc_sts_t sts,
  output rdmc_pkg::rdmc_cmd_t cmd
);
  import rdmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_UP,
    S_RD_MID,
    S_RD_DOWN,
    S_DECIDE
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  // The result register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    cmd.rd_row = ROW_NONE;
    cmd.res    = RES_REJECT;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (mode == MODE_RESTART) begin
            cmd.restart = 1'b1;
            cmd.load    = 1'b1;
            cmd.res     = RES_RESTART;
          end else if (sts.done) begin
            cmd.load = 1'b1;
            cmd.res  = RES_FINISH;
          end else begin
            cmd.rd_row = ROW_UP;
            state_next = S_RD_MID;
          end
        end
      end
      S_RD_UP: begin
        cmd.rd_row = ROW_UP;
        state_next = S_RD_MID;
      end
      S_RD_MID: begin
        cmd.rd_row = ROW_MID;
        state_next = S_RD_DOWN;
      end
      S_RD_DOWN: begin
        cmd.rd_row = ROW_DOWN;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.unvisited) begin
          // Dead end: step back, or end the walk at the start cell or where the parent link leaves the grid.
          if (sts.at_start || !sts.parent_ok) begin
            if (out_free) begin
              cmd.set_done = 1'b1;
              cmd.load     = 1'b1;
              cmd.res      = RES_FINISH;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.back_step = 1'b1;
            state_next    = S_RD_UP;
          end
        end else if (out_free) begin
          cmd.carve  = sts.draw_ok;
          cmd.load   = 1'b1;
          cmd.res    = sts.draw_ok ? RES_CARVE : RES_REJECT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/rdmc_checker.sv */
// ----------------------------------------------------------------------------
// rdmc_checker: port-level checks for the maze carver
// Watches the word channels of the top level and flags results that the
// carving rules cannot produce.
// ----------------------------------------------------------------------------
module rdmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       carved,
  input logic [6:0] wall_x,
  input logic [6:0] wall_y,
  input logic       finished
);
  import rdmc_pkg::*;

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(carved) && $stable(wall_x)
      && $stable(wall_y) && $stable(finished))
    else $error("result word changed while stalled");

  // A word that carves never reports the walk as ended.
  a_carve_not_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && carved |-> !finished)
    else $error("carved and finished together");

  // An opened wall lies between two cells: odd on exactly one axis.
  a_wall_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && carved |-> (wall_x[0] ^ wall_y[0]))
    else $error("wall pixel not between two cells");

  // Without a carve the wall coordinates read zero.
  a_no_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !carved |-> wall_x == 7'd0 && wall_y == 7'd0)
    else $error("wall coordinates set without a carve");

  // A restart answers in the next cycle with a plain result.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_RESTART |=> out_valid && !carved && !finished)
    else $error("restart result missing or wrong");

endmodule

bind random_dfs_maze_carver_core rdmc_checker u_rdmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .carved    (carved),
  .wall_x    (wall_x),
  .wall_y    (wall_y),
  .finished  (finished)
);

/* tb/random_dfs_maze_carver_core_tb.sv */
// ----------------------------------------------------------------------------
// random_dfs_maze_carver_core_tb: self-checking bench for the maze carver
// Walks a short table of directed words through the block, then runs many
// random walks on grids of varied size and start cell. Every result word is
// compared field by field against a typed-in word or an in-bench model of the
// backtracking walk, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module random_dfs_maze_carver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdmc_pkg::*;

  localparam int GRID_MAX      = RDMC_MAX_SIDE;
  localparam int CELL_COUNT    = GRID_MAX * GRID_MAX;
  localparam int RANDOM_WORDS  = 1750;
  localparam int IDLE_LIMIT    = 100000;
  localparam int TAIL_CYCLES   = 64;
  localparam int NUM_ROWS      = 26;

  // One result word as the block reports it.
  typedef struct packed {
    logic       carved;
    logic [6:0] wall_x;
    logic [6:0] wall_y;
    logic       finished;
  } maze_result_t;

  // One row of the directed table: a register write or an input word.
  typedef enum logic {ACT_WRITE, ACT_WORD} act_kind_t;

  typedef struct packed {
    act_kind_t    act;
    logic [1:0]   reg_idx;
    logic [6:0]   value;
    logic         m;
    logic [1:0]   d;
    logic         typed;
    maze_result_t res;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       mode      = MODE_RESTART;
  logic [1:0] draw      = DIR_UP;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       carved;
  logic [6:0] wall_x;
  logic [6:0] wall_y;
  logic       finished;

  // Walk model state: registers as written, and the walk as latched at restart.
  logic [6:0] cfg_side    = CELLS_PER_SIDE_RST;
  logic [5:0] cfg_start_x = START_X_RST;
  logic [5:0] cfg_start_y = START_Y_RST;
  int         grid_side   = 2;
  int         start_col   = 0;
  int         start_row   = 0;
  int         walker_col  = 0;
  int         walker_row  = 0;
  bit         walk_done   = 1'b1;
  bit         visited   [CELL_COUNT];
  bit [1:0]   parent_dir[CELL_COUNT];

  maze_result_t pending_results[$];
  maze_result_t want;
  int           fail_count = 0;
  int           words_sent = 0;
  int           burst_left = 0;
  int           idle_cycles;
  int           stall_style = 0;
  int           style_left  = 0;

  random_dfs_maze_carver_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .draw     (draw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .carved   (carved),
    .wall_x   (wall_x),
    .wall_y   (wall_y),
    .finished (finished)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int cell_at(int x, int y);
    return (y * GRID_MAX + x) % CELL_COUNT;
  endfunction

  // Cell next to (x,y) in the given direction; 0 when it falls off the grid.
  function automatic bit neighbor_of(int x, int y, logic [1:0] dir,
                                     output int nx, output int ny);
    nx = x;
    ny = y;
    case (dir)
      DIR_UP: begin
        if (y == 0) return 1'b0;
        ny = y - 1;
      end
      DIR_RIGHT: begin
        if (x + 1 >= grid_side) return 1'b0;
        nx = x + 1;
      end
      DIR_DOWN: begin
        if (y + 1 >= grid_side) return 1'b0;
        ny = y + 1;
      end
      default: begin
        if (x == 0) return 1'b0;
        nx = x - 1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic bit has_open_neighbor(int x, int y);
    int nx;
    int ny;
    for (int k = 0; k < 4; k++) begin
      if (neighbor_of(x, y, k[1:0], nx, ny) && !visited[cell_at(nx, ny)]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the walk by one input word and returns the result it causes.
  function automatic maze_result_t carve_step(logic m, logic [1:0] d);
    maze_result_t r;
    int nx;
    int ny;
    int steps;
    r = '0;
    if (m == MODE_RESTART) begin
      grid_side  = (int'(cfg_side) < 2) ? 2 :
                   (int'(cfg_side) > GRID_MAX) ? GRID_MAX : int'(cfg_side);
      start_col  = (int'(cfg_start_x) < grid_side) ? int'(cfg_start_x) : grid_side - 1;
      start_row  = (int'(cfg_start_y) < grid_side) ? int'(cfg_start_y) : grid_side - 1;
      visited    = '{default: 1'b0};
      walker_col = start_col;
      walker_row = start_row;
      visited[cell_at(walker_col, walker_row)] = 1'b1;
      walk_done  = 1'b0;
    end else if (walk_done) begin
      r.finished = 1'b1;
    end else begin
      // Back up along the parent links until a cell with an open neighbor.
      steps = 0;
      while (!has_open_neighbor(walker_col, walker_row)) begin
        if ((walker_col == start_col && walker_row == start_row) || steps >= CELL_COUNT) begin
          walk_done = 1'b1;
          break;
        end
        if (!neighbor_of(walker_col, walker_row,
                         parent_dir[cell_at(walker_col, walker_row)], nx, ny)) begin
          walk_done = 1'b1;
          break;
        end
        walker_col = nx;
        walker_row = ny;
        steps++;
      end
      if (walk_done) begin
        r.finished = 1'b1;
      end else if (neighbor_of(walker_col, walker_row, d, nx, ny)
                   && !visited[cell_at(nx, ny)]) begin
        r.carved = 1'b1;
        r.wall_x = 7'(walker_col + nx);
        r.wall_y = 7'(walker_row + ny);
        visited[cell_at(nx, ny)]    = 1'b1;
        parent_dir[cell_at(nx, ny)] = d + 2'd2;
        walker_col = nx;
        walker_row = ny;
      end
    end
    return r;
  endfunction

  // Sends one input word, opening a random gap when a burst runs out.
  task automatic send_word(input logic m, input logic [1:0] d,
                           input logic typed, input maze_result_t typed_res);
    maze_result_t model_res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    mode     <= m;
    draw     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_res = carve_step(m, d);
    pending_results.push_back(typed ? typed_res : model_res);
    words_sent++;
  endtask

  // Stops the input channel and waits until every result word has come back.
  task automatic drain_input();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write: setup phase, access phase until pready, then back to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CELLS_PER_SIDE: cfg_side = value;
      REG_START_X:        cfg_start_x = value[5:0];
      REG_START_Y:        cfg_start_y = value[5:0];
      default: ;
    endcase
  endtask

  // Directed table. Expected words are typed in only where they are obvious.
  dir_row_t dir_rows [NUM_ROWS];

  initial begin
    dir_rows = '{
      // A draw straight after reset finds the walk idle.
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b1,
        '{1'b0, 7'd0,   7'd0,   1'b1}},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_RESTART, DIR_UP,    1'b1, '0},
      // Draws off the top and left edge of the grid are rejected.
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_LEFT,  1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_RIGHT, 1'b1,
        '{1'b1, 7'd1,   7'd0,   1'b0}},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_LEFT,  1'b0, '0},
      // Oversized side clamps to the maximum; the start moves to the far corner.
      '{ACT_WRITE, REG_CELLS_PER_SIDE, 7'd127, MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WRITE, REG_START_X,        7'd63,  MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WRITE, REG_START_Y,        7'd63,  MODE_DRAW,    DIR_UP,    1'b0, '0},
      // The old walk goes on until the next restart picks up the new setting.
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_DOWN,  1'b0, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_RESTART, DIR_LEFT,  1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_DOWN,  1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_RIGHT, 1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b1,
        '{1'b1, 7'd126, 7'd125, 1'b0}},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_LEFT,  1'b1,
        '{1'b1, 7'd125, 7'd124, 1'b0}},
      // Smallest grid with a start that clamps to the corner; walk it to the end.
      '{ACT_WRITE, REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WRITE, REG_START_X,        7'd5,   MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WRITE, REG_START_Y,        7'd5,   MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_RESTART, DIR_RIGHT, 1'b1, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_LEFT,  1'b0, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_DOWN,  1'b0, '0},
      // Backtracking to the start ends the walk; later draws keep reporting it.
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_RIGHT, 1'b1,
        '{1'b0, 7'd0,   7'd0,   1'b1}},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_DRAW,    DIR_UP,    1'b1,
        '{1'b0, 7'd0,   7'd0,   1'b1}},
      '{ACT_WRITE, REG_CELLS_PER_SIDE, 7'd1,   MODE_DRAW,    DIR_UP,    1'b0, '0},
      '{ACT_WORD,  REG_CELLS_PER_SIDE, 7'd0,   MODE_RESTART, DIR_DOWN,  1'b1, '0}
    };
  end

  // Main stimulus: reset, directed table, then random walks.
  initial begin
    int pick;
    int draws;
    int budget;
    int extra;
    logic [6:0] side_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].act == ACT_WRITE) begin
        drain_input();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].m, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random walks, mostly on small grids, now and then on the largest one.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      drain_input();
      pick = $urandom_range(0, 19);
      if (pick == 0)      side_val = 7'd64;
      else if (pick == 1) side_val = 7'($urandom_range(0, 1));
      else if (pick == 2) side_val = 7'($urandom_range(65, 127));
      else                side_val = 7'($urandom_range(2, 8));
      if ($urandom_range(0, 3) != 0) write_reg(REG_CELLS_PER_SIDE, side_val);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_START_X, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 63))
                                                           : 7'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_START_Y, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 63))
                                                           : 7'($urandom_range(0, 7)));

      // Occasionally leave the restart out so draws hit a finished walk.
      if ($urandom_range(0, 9) != 0)
        send_word(MODE_RESTART, 2'($urandom_range(0, 3)), 1'b0, '0);
      budget = (grid_side > 8) ? 120 : 600;
      extra  = $urandom_range(0, 3);
      draws  = 0;
      while (draws < budget && (!walk_done || extra > 0) && words_sent < RANDOM_WORDS) begin
        if (walk_done) extra--;
        if ($urandom_range(0, 99) == 0)
          send_word(MODE_RESTART, 2'($urandom_range(0, 3)), 1'b0, '0);
        else
          send_word(MODE_DRAW, 2'($urandom_range(0, 3)), 1'b0, '0);
        draws++;
      end
    end

    drain_input();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("random_dfs_maze_carver_core_tb OK");
    end else begin
      $display("random_dfs_maze_carver_core_tb NOT OK");
    end
    $finish;
  end

  // Result side backpressure: the stall style is redrawn whenever its random hold count runs out.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(8, 64);
      end else begin
        style_left--;
      end
      case (stall_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      fail_count++;
    end
  endtask

  // Compare every accepted result word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with none expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("carved",   int'(want.carved),   int'(carved));
        check_field("wall_x",   int'(want.wall_x),   int'(wall_x));
        check_field("wall_y",   int'(want.wall_y),   int'(wall_y));
        check_field("finished", int'(want.finished), int'(finished));
      end
    end
  end

  // Watchdog: too many cycles in a row without a word moving on either side.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("random_dfs_maze_carver_core_tb NOT OK");
    $finish;
  end

endmodule
